// ----- hdl/mqttfr_pkg.sv -----
// Package for the MQTT receive framer: phase and error codes, configuration
// and result structures, and the fixed-header check. No dependencies.
`default_nettype none

package mqttfr_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_TYPE     = 3'd1,
        ERR_FLAGS    = 3'd2,
        ERR_OVERFLOW = 3'd3,
        ERR_LENGTH   = 3'd4,
        ERR_TIMEOUT  = 3'd5
    } t_err;

    localparam logic [1:0] CFG_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

    localparam logic [15:0] CAPACITY_RESET = 16'd256;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;

    localparam logic [3:0] PT_CONNECT   = 4'd1;
    localparam logic [3:0] PT_CONNACK   = 4'd2;
    localparam logic [3:0] PT_PUBLISH   = 4'd3;
    localparam logic [3:0] PT_SUBSCRIBE = 4'd8;
    localparam logic [3:0] PT_SUBACK    = 4'd9;
    localparam logic [3:0] PT_PINGREQ   = 4'd12;
    localparam logic [3:0] PT_PINGRESP  = 4'd13;

    localparam logic [3:0] FLAGS_NONE      = 4'h0;
    localparam logic [3:0] FLAGS_SUBSCRIBE = 4'h2;

    typedef struct packed {
        logic        enable;
        logic [15:0] capacity;
        logic [15:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        accepted;
        logic        frame_start;
        logic        frame_end;
        t_err        error;
        logic [3:0]  packet_type;
        logic [27:0] remaining_length;
    } t_result;

    function automatic t_err check_header(input logic [7:0] hdr);
        logic [3:0] ptype;
        logic [3:0] flags;
        t_err       err;
        ptype = hdr[7:4];
        flags = hdr[3:0];
        unique case (ptype)
            PT_CONNECT, PT_CONNACK, PT_SUBACK, PT_PINGREQ, PT_PINGRESP: begin
                err = (flags == FLAGS_NONE) ? ERR_NONE : ERR_FLAGS;
            end
            PT_SUBSCRIBE: begin
                err = (flags == FLAGS_SUBSCRIBE) ? ERR_NONE : ERR_FLAGS;
            end
            PT_PUBLISH: begin
                err = ERR_NONE;
            end
            default: begin
                err = ERR_TYPE;
            end
        endcase
        return err;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mqtt_frame_receiver.sv -----
// Top level of the MQTT receive framer: configuration registers, output
// register with skid stage, and the framing core. Depends on mqttfr_pkg, mqttfr_core.
`default_nettype none

// Every input beat (a received byte or a time tick) yields exactly one result
// beat. One beat is taken per clock cycle while o_stall is low; its result is
// registered in the output register, or in the skid register when the output
// register cannot take it. The framing state is updated by a single pass of
// compare and shift-add logic, so a new beat may follow in the next cycle. A
// one-entry skid register behind the output lets o_stall come straight from a
// flop. Configuration writes are always ready and should only be issued while no beat is in flight.
module mqtt_frame_receiver (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,

    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_kind,
    input  wire  [7:0]  i_rx_byte,

    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_byte_out,
    output logic        o_accepted,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic [2:0]  o_error,
    output logic [3:0]  o_packet_type,
    output logic [27:0] o_remaining_length
);

    mqttfr_pkg::t_cfg    r_cfg;
    mqttfr_pkg::t_result core_res;
    mqttfr_pkg::t_result r_out;
    mqttfr_pkg::t_result r_skd;
    logic                r_out_valid;
    logic                r_skd_valid;
    logic                in_accept;
    logic                out_free;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skd_valid;
    assign in_accept   = i_valid && !r_skd_valid;
    assign out_free    = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= 1'b0;
            r_cfg.capacity <= mqttfr_pkg::CAPACITY_RESET;
            r_cfg.timeout  <= mqttfr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mqttfr_pkg::CFG_ENABLE:   r_cfg.enable   <= i_cfg_data[0];
                mqttfr_pkg::CFG_CAPACITY: r_cfg.capacity <= i_cfg_data;
                mqttfr_pkg::CFG_TIMEOUT:  r_cfg.timeout  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mqttfr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_cfg     (r_cfg),
        .i_kind    (i_kind),
        .i_rx_byte (i_rx_byte),
        .o_result  (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_skd_valid || in_accept;
            r_skd_valid <= r_skd_valid && in_accept;
        end else if (in_accept) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skd_valid) begin
                r_out <= r_skd;
                if (in_accept) begin
                    r_skd <= core_res;
                end
            end else if (in_accept) begin
                r_out <= core_res;
            end
        end else if (in_accept) begin
            r_skd <= core_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_byte_out         = r_out.byte_out;
    assign o_accepted         = r_out.accepted;
    assign o_frame_start      = r_out.frame_start;
    assign o_frame_end        = r_out.frame_end;
    assign o_error            = 3'(r_out.error);
    assign o_packet_type      = r_out.packet_type;
    assign o_remaining_length = r_out.remaining_length;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output register is empty");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out))
        else $error("a stalled result beat changed or was dropped");

    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> !in_accept)
        else $error("an input beat was taken while the input was stalled");

endmodule

`default_nettype wire

// ----- hdl/mqttfr_core.sv -----
// Framing state and per-beat decision logic of the MQTT receive framer.
// Depends on mqttfr_pkg.
`default_nettype none

module mqttfr_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire mqttfr_pkg::t_cfg i_cfg,
    input  wire                   i_kind,
    input  wire  [7:0]            i_rx_byte,
    output mqttfr_pkg::t_result   o_result
);

    mqttfr_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_frame_bytes, n_frame_bytes;
    logic [27:0] r_bytes_left, n_bytes_left;
    logic [1:0]  r_digit_idx, n_digit_idx;
    logic [15:0] r_quiet, n_quiet;
    logic [3:0]  r_type, n_type;
    logic [27:0] r_frame_length, n_frame_length;

    logic [15:0] quiet_inc;
    logic [15:0] frame_bytes_inc;
    logic [27:0] digit_term;
    logic [27:0] digit_sum;
    logic [27:0] left_dec;
    mqttfr_pkg::t_err hdr_err;
    mqttfr_pkg::t_result res;

    assign quiet_inc       = (r_quiet == 16'hFFFF) ? r_quiet : r_quiet + 16'd1;
    assign frame_bytes_inc = r_frame_bytes + 16'd1;
    assign digit_sum       = r_bytes_left + digit_term;
    assign left_dec        = (r_bytes_left != 28'd0) ? r_bytes_left - 28'd1 : 28'd0;
    assign hdr_err         = mqttfr_pkg::check_header(i_rx_byte);

    always_comb begin
        unique case (r_digit_idx)
            2'd0:    digit_term = {21'd0, i_rx_byte[6:0]};
            2'd1:    digit_term = {14'd0, i_rx_byte[6:0], 7'd0};
            2'd2:    digit_term = {7'd0, i_rx_byte[6:0], 14'd0};
            default: digit_term = {i_rx_byte[6:0], 21'd0};
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_frame_bytes  = r_frame_bytes;
        n_bytes_left   = r_bytes_left;
        n_digit_idx    = r_digit_idx;
        n_quiet        = r_quiet;
        n_type         = r_type;
        n_frame_length = r_frame_length;

        res.byte_out         = i_kind ? 8'd0 : i_rx_byte;
        res.accepted         = 1'b0;
        res.frame_start      = 1'b0;
        res.frame_end        = 1'b0;
        res.error            = mqttfr_pkg::ERR_NONE;
        res.packet_type      = r_type;
        res.remaining_length = 28'd0;

        if (!i_cfg.enable) begin
            n_phase = mqttfr_pkg::PH_HEADER;
            if (!i_kind) begin
                res.packet_type = i_rx_byte[7:4];
            end
        end else if (i_kind) begin
            if (r_phase != mqttfr_pkg::PH_HEADER) begin
                if (r_phase == mqttfr_pkg::PH_DATA) begin
                    res.remaining_length = r_frame_length;
                end
                n_quiet = quiet_inc;
                if (quiet_inc >= i_cfg.timeout) begin
                    res.error = mqttfr_pkg::ERR_TIMEOUT;
                    n_phase   = mqttfr_pkg::PH_HEADER;
                end
            end
        end else begin
            unique case (r_phase)
                mqttfr_pkg::PH_HEADER: begin
                    res.packet_type = i_rx_byte[7:4];
                    res.error       = hdr_err;
                    if (hdr_err == mqttfr_pkg::ERR_NONE) begin
                        if (i_cfg.capacity == 16'd0) begin
                            res.error = mqttfr_pkg::ERR_OVERFLOW;
                        end else begin
                            res.accepted    = 1'b1;
                            res.frame_start = 1'b1;
                            n_type          = i_rx_byte[7:4];
                            n_frame_bytes   = 16'd1;
                            n_bytes_left    = 28'd0;
                            n_frame_length  = 28'd0;
                            n_digit_idx     = 2'd0;
                            n_quiet         = 16'd0;
                            n_phase         = mqttfr_pkg::PH_LENGTH;
                        end
                    end
                end
                mqttfr_pkg::PH_LENGTH: begin
                    n_quiet = 16'd0;
                    if (r_frame_bytes >= i_cfg.capacity) begin
                        res.error = mqttfr_pkg::ERR_OVERFLOW;
                        n_phase   = mqttfr_pkg::PH_HEADER;
                    end else if (i_rx_byte[7] && (r_digit_idx == 2'd3)) begin
                        res.error = mqttfr_pkg::ERR_LENGTH;
                        n_phase   = mqttfr_pkg::PH_HEADER;
                    end else begin
                        res.accepted  = 1'b1;
                        n_frame_bytes = frame_bytes_inc;
                        n_bytes_left  = digit_sum;
                        if (i_rx_byte[7]) begin
                            n_digit_idx = r_digit_idx + 2'd1;
                        end else begin
                            n_frame_length       = digit_sum;
                            res.remaining_length = digit_sum;
                            if (digit_sum == 28'd0) begin
                                res.frame_end = 1'b1;
                                n_phase       = mqttfr_pkg::PH_HEADER;
                            end else begin
                                n_phase = mqttfr_pkg::PH_DATA;
                            end
                        end
                    end
                end
                default: begin
                    n_quiet              = 16'd0;
                    res.remaining_length = r_frame_length;
                    if (r_frame_bytes >= i_cfg.capacity) begin
                        res.error = mqttfr_pkg::ERR_OVERFLOW;
                        n_phase   = mqttfr_pkg::PH_HEADER;
                    end else begin
                        res.accepted  = 1'b1;
                        n_frame_bytes = frame_bytes_inc;
                        n_bytes_left  = left_dec;
                        if (left_dec == 28'd0) begin
                            res.frame_end = 1'b1;
                            n_phase       = mqttfr_pkg::PH_HEADER;
                        end
                    end
                end
            endcase
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= mqttfr_pkg::PH_HEADER;
            r_frame_bytes  <= 16'd0;
            r_bytes_left   <= 28'd0;
            r_digit_idx    <= 2'd0;
            r_quiet        <= 16'd0;
            r_type         <= 4'd0;
            r_frame_length <= 28'd0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_frame_bytes  <= n_frame_bytes;
            r_bytes_left   <= n_bytes_left;
            r_digit_idx    <= n_digit_idx;
            r_quiet        <= n_quiet;
            r_type         <= n_type;
            r_frame_length <= n_frame_length;
        end
    end

    a_start_to_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && res.frame_start |=> r_phase == mqttfr_pkg::PH_LENGTH)
        else $error("frame start did not move to the length phase");

    a_end_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && res.frame_end |=> r_phase == mqttfr_pkg::PH_HEADER)
        else $error("frame end did not return to header search");

    a_error_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (res.error != mqttfr_pkg::ERR_NONE) |-> !res.accepted)
        else $error("a byte was taken into the frame while an error was reported");

endmodule

`default_nettype wire

// ----- verif/tb_mqtt_frame_receiver.sv -----
// Testbench for mqtt_frame_receiver: drives byte and tick beats, predicts every
// result beat with its own framing model and checks it. Depends on mqttfr_pkg, mqtt_frame_receiver.
`timescale 1ns / 1ps

class frame_scoreboard;
    bit          enable;
    bit [15:0]   capacity;
    bit [15:0]   timeout;

    mqttfr_pkg::t_phase phase;
    bit [15:0]   frame_bytes;
    bit [27:0]   bytes_left;
    bit [2:0]    digit_idx;
    bit [15:0]   quiet_ticks;
    bit [3:0]    cur_type;
    bit [27:0]   frame_len;

    mqttfr_pkg::t_result expected_results[$];
    int          errors;

    function new();
        enable      = 1'b0;
        capacity    = mqttfr_pkg::CAPACITY_RESET;
        timeout     = mqttfr_pkg::TIMEOUT_RESET;
        phase       = mqttfr_pkg::PH_HEADER;
        frame_bytes = '0;
        bytes_left  = '0;
        digit_idx   = '0;
        quiet_ticks = '0;
        cur_type    = '0;
        frame_len   = '0;
        errors      = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [15:0] data);
        case (idx)
            mqttfr_pkg::CFG_ENABLE:   enable = data[0];
            mqttfr_pkg::CFG_CAPACITY: capacity = data;
            mqttfr_pkg::CFG_TIMEOUT:  timeout = data;
            default: ;
        endcase
    endfunction

    function mqttfr_pkg::t_err header_fault(bit [7:0] b);
        bit [3:0] flags;
        flags = b[3:0];
        if (b[7:4] == mqttfr_pkg::PT_PUBLISH) return mqttfr_pkg::ERR_NONE;
        if (b[7:4] == mqttfr_pkg::PT_SUBSCRIBE) begin
            return (flags == mqttfr_pkg::FLAGS_SUBSCRIBE) ?
                   mqttfr_pkg::ERR_NONE : mqttfr_pkg::ERR_FLAGS;
        end
        if (b[7:4] == mqttfr_pkg::PT_CONNECT || b[7:4] == mqttfr_pkg::PT_CONNACK ||
            b[7:4] == mqttfr_pkg::PT_SUBACK || b[7:4] == mqttfr_pkg::PT_PINGREQ ||
            b[7:4] == mqttfr_pkg::PT_PINGRESP) begin
            return (flags == mqttfr_pkg::FLAGS_NONE) ?
                   mqttfr_pkg::ERR_NONE : mqttfr_pkg::ERR_FLAGS;
        end
        return mqttfr_pkg::ERR_TYPE;
    endfunction

    function void note_beat(bit is_tick, bit [7:0] b);
        mqttfr_pkg::t_result r;
        r = '0;
        r.error = mqttfr_pkg::ERR_NONE;
        r.byte_out = is_tick ? 8'd0 : b;
        r.packet_type = cur_type;
        if (!enable) begin
            phase = mqttfr_pkg::PH_HEADER;
            if (!is_tick) r.packet_type = b[7:4];
        end else if (is_tick) begin
            if (phase != mqttfr_pkg::PH_HEADER) begin
                if (phase == mqttfr_pkg::PH_DATA) r.remaining_length = frame_len;
                if (quiet_ticks != 16'hFFFF) quiet_ticks++;
                if (quiet_ticks >= timeout) begin
                    r.error = mqttfr_pkg::ERR_TIMEOUT;
                    phase = mqttfr_pkg::PH_HEADER;
                end
            end
        end else if (phase == mqttfr_pkg::PH_HEADER) begin
            r.packet_type = b[7:4];
            r.error = header_fault(b);
            if (r.error == mqttfr_pkg::ERR_NONE) begin
                if (capacity == 16'd0) begin
                    r.error = mqttfr_pkg::ERR_OVERFLOW;
                end else begin
                    r.accepted = 1'b1;
                    r.frame_start = 1'b1;
                    cur_type = b[7:4];
                    frame_bytes = 16'd1;
                    bytes_left = '0;
                    frame_len = '0;
                    digit_idx = '0;
                    quiet_ticks = '0;
                    phase = mqttfr_pkg::PH_LENGTH;
                end
            end
        end else if (phase == mqttfr_pkg::PH_LENGTH) begin
            quiet_ticks = '0;
            if (frame_bytes >= capacity) begin
                r.error = mqttfr_pkg::ERR_OVERFLOW;
                phase = mqttfr_pkg::PH_HEADER;
            end else if (b[7] && digit_idx >= 3'd3) begin
                r.error = mqttfr_pkg::ERR_LENGTH;
                phase = mqttfr_pkg::PH_HEADER;
            end else begin
                r.accepted = 1'b1;
                frame_bytes++;
                bytes_left = bytes_left + (28'(b[6:0]) << (7 * digit_idx[1:0]));
                if (b[7]) begin
                    digit_idx++;
                end else begin
                    frame_len = bytes_left;
                    r.remaining_length = frame_len;
                    if (bytes_left == '0) begin
                        r.frame_end = 1'b1;
                        phase = mqttfr_pkg::PH_HEADER;
                    end else begin
                        phase = mqttfr_pkg::PH_DATA;
                    end
                end
            end
        end else begin
            quiet_ticks = '0;
            r.remaining_length = frame_len;
            if (frame_bytes >= capacity) begin
                r.error = mqttfr_pkg::ERR_OVERFLOW;
                phase = mqttfr_pkg::PH_HEADER;
            end else begin
                r.accepted = 1'b1;
                frame_bytes++;
                if (bytes_left != '0) bytes_left--;
                if (bytes_left == '0) begin
                    r.frame_end = 1'b1;
                    phase = mqttfr_pkg::PH_HEADER;
                end
            end
        end
        expected_results.push_back(r);
    endfunction

    function void compare_field(string fname, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $error("%s: expected %0h, got %0h", fname, e, a);
            errors++;
        end
    endfunction

    function void check_result(mqttfr_pkg::t_result got);
        mqttfr_pkg::t_result e;
        if (expected_results.size() == 0) begin
            $error("result beat arrived with no expectation waiting");
            errors++;
            return;
        end
        e = expected_results.pop_front();
        compare_field("byte_out", e.byte_out, got.byte_out);
        compare_field("accepted", e.accepted, got.accepted);
        compare_field("frame_start", e.frame_start, got.frame_start);
        compare_field("frame_end", e.frame_end, got.frame_end);
        compare_field("error", e.error, got.error);
        compare_field("packet_type", e.packet_type, got.packet_type);
        compare_field("remaining_length", e.remaining_length, got.remaining_length);
    endfunction
endclass

module tb_mqtt_frame_receiver;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_byte_out;
    logic        o_accepted;
    logic        o_frame_start;
    logic        o_frame_end;
    logic [2:0]  o_error;
    logic [3:0]  o_packet_type;
    logic [27:0] o_remaining_length;

    frame_scoreboard board;
    bit          hold_req = 1'b0;
    bit          steady = 1'b0;
    int          beats_sent = 0;

    mqtt_frame_receiver i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_rx_byte          (i_rx_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_byte_out         (o_byte_out),
        .o_accepted         (o_accepted),
        .o_frame_start      (o_frame_start),
        .o_frame_end        (o_frame_end),
        .o_error            (o_error),
        .o_packet_type      (o_packet_type),
        .o_remaining_length (o_remaining_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_mqtt_frame_receiver failed");
        $finish;
    end

    always @(posedge i_clk) begin
        mqttfr_pkg::t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.byte_out = o_byte_out;
            got.accepted = o_accepted;
            got.frame_start = o_frame_start;
            got.frame_end = o_frame_end;
            got.error = mqttfr_pkg::t_err'(o_error);
            got.packet_type = o_packet_type;
            got.remaining_length = o_remaining_length;
            board.check_result(got);
        end
    end

    // The receiver opens and closes at random; one long hold lets the block fill up.
    initial begin
        int unsigned open_len;
        int unsigned shut_len;
        int unsigned r;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (64) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) open_len = $urandom_range(50, 150);
                else if (r < 70) open_len = $urandom_range(1, 4);
                else open_len = $urandom_range(5, 20);
                r = $urandom_range(0, 99);
                if (r < 50) shut_len = 0;
                else if (r < 90) shut_len = $urandom_range(1, 3);
                else shut_len = $urandom_range(4, 30);
                i_stall <= 1'b0;
                repeat (open_len) @(posedge i_clk);
                if (shut_len > 0) begin
                    i_stall <= 1'b1;
                    repeat (shut_len) @(posedge i_clk);
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic put_beat(bit kind, bit [7:0] b);
        int unsigned gap;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        board.note_beat(kind, b);
        beats_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic put_byte(bit [7:0] b);
        put_beat(1'b0, b);
    endtask

    task automatic put_tick();
        put_beat(1'b1, 8'($urandom));
    endtask

    task automatic cfg_write(bit [1:0] idx, bit [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(bit en, bit [15:0] cap, bit [15:0] tmo);
        drain();
        cfg_write(mqttfr_pkg::CFG_ENABLE, {15'd0, en});
        cfg_write(mqttfr_pkg::CFG_CAPACITY, cap);
        cfg_write(mqttfr_pkg::CFG_TIMEOUT, tmo);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic bit [7:0] good_header();
        case ($urandom_range(0, 6))
            0: return {mqttfr_pkg::PT_CONNECT, mqttfr_pkg::FLAGS_NONE};
            1: return {mqttfr_pkg::PT_CONNACK, mqttfr_pkg::FLAGS_NONE};
            2: return {mqttfr_pkg::PT_PUBLISH, 4'($urandom)};
            3: return {mqttfr_pkg::PT_SUBSCRIBE, mqttfr_pkg::FLAGS_SUBSCRIBE};
            4: return {mqttfr_pkg::PT_SUBACK, mqttfr_pkg::FLAGS_NONE};
            5: return {mqttfr_pkg::PT_PINGREQ, mqttfr_pkg::FLAGS_NONE};
            default: return {mqttfr_pkg::PT_PINGRESP, mqttfr_pkg::FLAGS_NONE};
        endcase
    endfunction

    function automatic bit [7:0] bad_header();
        bit [3:0] t;
        bit [3:0] f;
        if ($urandom_range(0, 1) == 0) begin
            do t = 4'($urandom);
            while (t inside {mqttfr_pkg::PT_CONNECT, mqttfr_pkg::PT_CONNACK,
                             mqttfr_pkg::PT_PUBLISH, mqttfr_pkg::PT_SUBSCRIBE,
                             mqttfr_pkg::PT_SUBACK, mqttfr_pkg::PT_PINGREQ,
                             mqttfr_pkg::PT_PINGRESP});
            return {t, 4'($urandom)};
        end
        if ($urandom_range(0, 3) == 0) begin
            do f = 4'($urandom); while (f == mqttfr_pkg::FLAGS_SUBSCRIBE);
            return {mqttfr_pkg::PT_SUBSCRIBE, f};
        end
        f = 4'($urandom_range(1, 15));
        case ($urandom_range(0, 4))
            0: return {mqttfr_pkg::PT_CONNECT, f};
            1: return {mqttfr_pkg::PT_CONNACK, f};
            2: return {mqttfr_pkg::PT_SUBACK, f};
            3: return {mqttfr_pkg::PT_PINGREQ, f};
            default: return {mqttfr_pkg::PT_PINGRESP, f};
        endcase
    endfunction

    // Sends the first 'count' digits of a length field of 'digits' digits.
    task automatic put_length(int unsigned len, int unsigned digits, int unsigned count);
        bit [7:0] d;
        for (int i = 0; i < count; i++) begin
            d = 8'((len >> (7 * i)) & 32'h7F);
            if (i < digits - 1) d[7] = 1'b1;
            put_byte(d);
        end
    endtask

    function automatic int unsigned min_digits(int unsigned len);
        if (len < 128) return 1;
        if (len < 16384) return 2;
        if (len < 2097152) return 3;
        return 4;
    endfunction

    task automatic put_frame();
        int unsigned len;
        int unsigned digits;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 8);
        else if (r < 95) len = $urandom_range(9, 60);
        else len = $urandom_range(61, 300);
        digits = min_digits(len);
        if ($urandom_range(0, 5) == 0) digits = $urandom_range(digits, 4);
        put_byte(good_header());
        put_length(len, digits, digits);
        for (int i = 0; i < len; i++) begin
            if (board.timeout >= 2 && $urandom_range(0, 19) == 0) put_tick();
            put_byte(8'($urandom));
        end
    endtask

    task automatic put_abandoned_frame();
        int unsigned len;
        int unsigned digits;
        int unsigned sent;
        int unsigned ticks;
        if (board.timeout <= 40) len = $urandom_range(1, 28'hFFFFFFF);
        else len = $urandom_range(1, 20);
        if ($urandom_range(0, 3) == 0 && board.timeout <= 40) len = $urandom_range(1, 40);
        digits = min_digits(len);
        sent = $urandom_range(0, digits);
        put_byte(good_header());
        put_length(len, digits, sent);
        if (sent == digits) begin
            repeat ($urandom_range(0, (len > 6) ? 5 : len - 1)) put_byte(8'($urandom));
        end
        ticks = (board.timeout <= 40) ? board.timeout : 3;
        repeat (ticks) put_tick();
    endtask

    task automatic put_random_sequence();
        int unsigned r;
        steady = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 55) begin
            put_frame();
        end else if (r < 65) begin
            put_abandoned_frame();
        end else if (r < 73) begin
            put_byte(good_header());
            repeat (3) put_byte(8'h80 | 8'($urandom));
            put_byte(8'h80 | 8'($urandom));
        end else if (r < 83) begin
            put_byte(bad_header());
        end else if (r < 93) begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) put_tick();
        end
    endtask

    task automatic run_phase(bit en, bit [15:0] cap, bit [15:0] tmo, int count);
        int goal;
        set_config(en, cap, tmo);
        goal = beats_sent + count;
        while (beats_sent < goal) put_random_sequence();
    endtask

    initial begin
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Receiver disabled after reset.
        put_byte(8'hFF);
        put_tick();
        set_config(1'b1, mqttfr_pkg::CAPACITY_RESET, 16'd2);
        put_tick();
        put_byte(8'h00);
        put_byte(8'hF5);
        put_byte({mqttfr_pkg::PT_CONNECT, 4'h1});
        put_byte({mqttfr_pkg::PT_SUBSCRIBE, 4'h3});
        put_byte({mqttfr_pkg::PT_SUBSCRIBE, mqttfr_pkg::FLAGS_SUBSCRIBE});
        put_byte(8'h00);
        put_byte({mqttfr_pkg::PT_PUBLISH, 4'hF});
        put_byte(8'h01);
        put_byte(8'hFF);
        // Largest remaining length, then abandoned by the idle timeout.
        put_byte({mqttfr_pkg::PT_PUBLISH, 4'h0});
        put_length(28'hFFFFFFF, 4, 4);
        put_tick();
        put_tick();
        // A fourth length byte that still carries the continuation bit.
        put_byte({mqttfr_pkg::PT_PUBLISH, 4'h0});
        repeat (4) put_byte(8'h80);

        hold_req = 1'b1;
        run_phase(1'b1, 16'hFFFF, 16'hFFFF, 200);
        run_phase(1'b1, 16'd1, 16'd1, 100);
        repeat (3) begin
            run_phase(1'b1, 16'($urandom_range(8, 64)), 16'($urandom_range(2, 10)), 150);
        end
        run_phase(1'b0, 16'd300, 16'd4, 40);
        run_phase(1'b1, mqttfr_pkg::CAPACITY_RESET, mqttfr_pkg::TIMEOUT_RESET, 150);
        run_phase(1'b1, 16'($urandom_range(2, 20)), 16'd1, 100);
        run_phase(1'b1, 16'd40, 16'($urandom_range(2, 6)), 200);

        drain();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.expected_results.size() == 0) begin
            $display("tb_mqtt_frame_receiver passed");
        end else begin
            $display("tb_mqtt_frame_receiver failed");
        end
        $finish;
    end

endmodule
